>>> hw/rtl/hfau_pkg.sv
// Shared types, codes and half-float helper functions for the half float arithmetic unit.
// No dependencies.
package hfau_pkg;

  localparam int MaxDecimals = 15;

  typedef enum logic [2:0] {
    FN_ADD = 3'd0, FN_SUB = 3'd1, FN_MUL = 3'd2, FN_DIV = 3'd3,
    FN_RECIP = 3'd4, FN_I2F = 3'd5, FN_I2FD = 3'd6, FN_F2I = 3'd7
  } func_t;

  typedef enum logic [2:0] {
    OP_LOAD, OP_MUL_AX, OP_SUB_TWO, OP_MUL_EST, OP_MUL_AR, OP_MUL_TENTH, OP_RECIP_CHK
  } op_t;

  typedef struct packed {
    logic op_en;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic recip_zero;
  } sts_t;

  localparam logic [15:0] HalfTwo = 16'h4000;
  localparam logic [15:0] HalfTen = 16'h4900;
  localparam logic [15:0] HalfInf = 16'h7C00;

  function automatic logic [4:0] msb_pos(input logic [31:0] v);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < 32; i++) if (v[i]) p = 5'(i);
    return p;
  endfunction

  function automatic logic [15:0] h_add(input logic [15:0] a, input logic [15:0] b);
    logic [4:0]  ea, eb, d;
    logic [10:0] ma, mb;
    logic [11:0] um;
    logic [15:0] sg;
    logic [3:0]  n;
    logic [6:0]  e;
    logic [10:0] sh;
    ea = a[14:10]; eb = b[14:10];
    if (ea == 5'd31) return a;
    if (eb == 5'd31) return b;
    ma = {1'b1, a[9:0]}; mb = {1'b1, b[9:0]};
    if (ea > eb) begin
      d = ea - eb; mb = mb >> d; e = {2'b0, ea};
    end else begin
      d = eb - ea; ma = ma >> d; e = {2'b0, eb};
    end
    if (a[15] == b[15]) begin
      um = {1'b0, ma} + {1'b0, mb}; sg = {a[15], 15'b0};
    end else if (!a[15]) begin
      if (ma >= mb) begin um = {1'b0, ma - mb}; sg = 16'h0; end
      else begin um = {1'b0, mb - ma}; sg = 16'h8000; end
    end else begin
      if (ma <= mb) begin um = {1'b0, mb - ma}; sg = 16'h0; end
      else begin um = {1'b0, ma - mb}; sg = 16'h8000; end
    end
    if (um < 12'd2) return sg;
    n = 4'(msb_pos({20'b0, um}));
    if (n >= 4'd10) sh = 11'(um >> (n - 4'd10));
    else sh = 11'(um << (4'd10 - n));
    e = e + 7'(n) - 7'd10;
    if (e[6]) return sg;
    return sg | {1'b0, e[4:0], sh[9:0]};
  endfunction

  function automatic logic [15:0] h_mul(input logic [15:0] a, input logic [15:0] b);
    logic [15:0] sg;
    logic [6:0]  e;
    logic [19:0] p;
    logic [11:0] um;
    logic [10:0] m;
    sg = {a[15] ^ b[15], 15'b0};
    if (a[14:0] == '0 || b[14:0] == '0) return sg;
    if (a[14:10] == 5'd31 || b[14:10] == 5'd31) return sg | HalfInf;
    e = 7'(a[14:10]) + 7'(b[14:10]) - 7'd15;
    if (e[6] || e == '0) return 16'h0;
    p = a[9:0] * b[9:0];
    um = 12'h400 + 12'(p[19:10]) + 12'(a[9:0]) + 12'(b[9:0]);
    m = 11'(um[9:0]);
    if (um[11]) begin m = 11'(um[10:1]); e = e + 7'd1; end
    if (um[0] && e != 7'd30) begin
      m = m + 11'd1;
      if (m[10]) begin m[10] = 1'b0; e = e + 7'd1; end
    end
    if (e > 7'd31) return sg | HalfInf;
    return sg | {1'b0, e[4:0], m[9:0]};
  endfunction

  function automatic logic [15:0] h_from_int(input logic [31:0] v);
    logic [31:0] mg;
    logic [4:0]  n;
    logic [5:0]  e;
    logic [31:0] sh;
    logic [15:0] sg;
    if (v == '0) return 16'h0;
    sg = {v[31], 15'b0};
    mg = v[31] ? (32'd0 - v) : v;
    n = msb_pos(mg);
    e = 6'(n) + 6'd15;
    if (e >= 6'd31) return sg | HalfInf;
    sh = (n >= 5'd10) ? (mg >> (n - 5'd10)) : (mg << (5'd10 - n));
    return sg | {1'b0, e[4:0], sh[9:0]};
  endfunction

  function automatic logic [31:0] h_to_int(input logic [15:0] x);
    logic [4:0]  e;
    logic [31:0] sc, mg;
    logic [41:0] pr;
    if (x[14:10] < 5'd15) return 32'h0;
    e = x[14:10] - 5'd15;
    sc = 32'd1 << e;
    pr = {10'b0, sc} * {32'b0, x[9:0]};
    mg = sc + 32'(pr >> 10);
    return x[15] ? (32'd0 - mg) : mg;
  endfunction

endpackage

>>> hw/rtl/half_float_arith_unit_core.sv
// Half float arithmetic unit: add, sub, mul, div, reciprocal and int conversions.
// Add, sub, mul and conversions finish at load; recip runs a seed check and Newton
// steps; div adds a multiply; I2FD is recip plus one multiply per decimal place.
// One word at a time; the shared multiplier in the datapath sets the step count.
// Reset (rst, synchronous) returns the sequencer to idle and the seed to 0x7800.
module half_float_arith_unit_core import hfau_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  func,
  input  logic [31:0] first_operand,
  input  logic [15:0] second_operand,
  input  logic [3:0]  decimal_places,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] result_value
);
  logic [15:0] seed;
  cmd_t cmd;
  sts_t sts;
  logic busy, in_fire;

  always_ff @(posedge clk) begin
    if (rst) seed <= 16'h7800;
    else if (cfg_we) seed <= cfg_wdata;
  end

  assign in_stall = busy;
  assign in_fire = in_valid && !busy;

  hfau_ctrl u_ctrl (
    .clk, .rst, .in_fire, .func, .decimal_places, .sts, .out_stall,
    .cmd, .busy, .out_valid
  );

  hfau_dp u_dp (
    .clk, .cmd, .seed, .func, .first_operand, .second_operand, .sts, .result_value
  );

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("accept while result pending");
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(result_value)))
    else $error("result dropped under stall");
  a_fire_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall) else $error("no busy after accept");
endmodule

>>> hw/rtl/hfau_ctrl.sv
// Sequencer for the half float arithmetic unit: steps the datapath per function.
// Depends on hfau_pkg.
module hfau_ctrl import hfau_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_fire,
  input  logic [2:0] func,
  input  logic [3:0] decimal_places,
  input  sts_t       sts,
  input  logic       out_stall,
  output cmd_t       cmd,
  output logic       busy,
  output logic       out_valid
);
  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_AX, S_SUB, S_EST, S_AX2, S_SUB2, S_EST2, S_POST, S_TEN, S_DONE
  } state_t;

  state_t     state;
  logic [2:0] fn;
  logic [3:0] cnt;

  assign busy = state != S_IDLE;
  assign out_valid = state == S_DONE;

  always_comb begin
    cmd = '{op_en: 1'b0, op: OP_LOAD};
    case (state)
      S_IDLE: cmd = '{op_en: in_fire, op: OP_LOAD};
      S_CHK:  cmd = '{op_en: 1'b1, op: OP_RECIP_CHK};
      S_AX, S_AX2:   cmd = '{op_en: 1'b1, op: OP_MUL_AX};
      S_SUB, S_SUB2: cmd = '{op_en: 1'b1, op: OP_SUB_TWO};
      S_EST, S_EST2: cmd = '{op_en: 1'b1, op: OP_MUL_EST};
      S_POST: cmd = '{op_en: 1'b1, op: OP_MUL_AR};
      S_TEN:  cmd = '{op_en: 1'b1, op: OP_MUL_TENTH};
      default: cmd = '{op_en: 1'b0, op: OP_LOAD};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fn <= '0;
      cnt <= '0;
    end else begin
      case (state)
        S_IDLE: if (in_fire) begin
          fn <= func;
          cnt <= decimal_places;
          if (func == FN_DIV || func == FN_RECIP || func == FN_I2FD) state <= S_CHK;
          else state <= S_DONE;
        end
        S_CHK: begin
          if (sts.recip_zero) state <= (fn == FN_DIV) ? S_POST : (fn == FN_I2FD ? S_TEN : S_DONE);
          else state <= S_AX;
        end
        S_AX:   state <= S_SUB;
        S_SUB:  state <= S_EST;
        S_EST:  state <= S_AX2;
        S_AX2:  state <= S_SUB2;
        S_SUB2: state <= S_EST2;
        S_EST2: state <= (fn == FN_DIV) ? S_POST : (fn == FN_I2FD ? S_TEN : S_DONE);
        S_POST: state <= S_DONE;
        S_TEN: begin
          if (cnt == '0) state <= S_DONE;
          else cnt <= cnt - 4'd1;
        end
        S_DONE: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> hw/rtl/hfau_dp.sv
// Datapath for the half float arithmetic unit: operand, estimate and result registers.
// Depends on hfau_pkg.
module hfau_dp import hfau_pkg::*; (
  input  logic        clk,
  input  cmd_t        cmd,
  input  logic [15:0] seed,
  input  logic [2:0]  func,
  input  logic [31:0] first_operand,
  input  logic [15:0] second_operand,
  output sts_t        sts,
  output logic [31:0] result_value
);
  logic [15:0] opa, x, est, tmp, tenth, acc;
  logic [31:0] res;
  logic [2:0]  fn;

  logic [15:0] mag;
  logic [15:0] mul_a, mul_b, mul_y, add_y;
  assign mag = {1'b0, x[14:0]};
  assign sts.recip_zero = mag >= seed;
  assign result_value = res;

  always_comb begin
    mul_a = mag; mul_b = est;
    case (cmd.op)
      OP_MUL_EST:   begin mul_a = est; mul_b = tmp; end
      OP_MUL_AR:    begin mul_a = opa; mul_b = res[15:0]; end
      OP_MUL_TENTH: begin mul_a = acc; mul_b = tenth; end
      default: ;
    endcase
  end
  assign mul_y = h_mul(mul_a, mul_b);
  assign add_y = h_add(HalfTwo, tmp ^ 16'h8000);

  always_ff @(posedge clk) begin
    if (cmd.op_en) begin
      case (cmd.op)
        OP_LOAD: begin
          fn <= func;
          opa <= first_operand[15:0];
          acc <= h_from_int(first_operand);
          if (func == FN_DIV) x <= second_operand;
          else if (func == FN_RECIP) x <= first_operand[15:0];
          else x <= HalfTen;
          case (func)
            FN_ADD:  res <= {16'b0, h_add(first_operand[15:0], second_operand)};
            FN_SUB:  res <= {16'b0, h_add(first_operand[15:0], second_operand ^ 16'h8000)};
            FN_MUL:  res <= {16'b0, h_mul(first_operand[15:0], second_operand)};
            FN_I2F, FN_I2FD: res <= {16'b0, h_from_int(first_operand)};
            FN_F2I:  res <= h_to_int(first_operand[15:0]);
            default: res <= '0;
          endcase
        end
        OP_RECIP_CHK: begin
          est <= seed - mag;
          res <= '0;
          tenth <= '0;
        end
        OP_MUL_AX:  tmp <= mul_y;
        OP_SUB_TWO: tmp <= add_y;
        OP_MUL_EST: begin
          est <= mul_y;
          res <= {16'b0, (x & 16'h8000) | mul_y};
          tenth <= (x & 16'h8000) | mul_y;
        end
        OP_MUL_AR:  res <= {16'b0, mul_y};
        OP_MUL_TENTH: begin
          if (fn == FN_I2FD) begin
            res <= {16'b0, acc};
            acc <= mul_y;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
